FILE: sv/lbfm_pkg.sv
// ----------------------------------------------------------------------------
// lbfm_pkg
// shared constants, codes and types of the lru buffer frame manager
// ----------------------------------------------------------------------------
package lbfm_pkg;

  localparam int unsigned FramesDef  = 16;
  localparam int unsigned DescsDef   = 8;
  localparam int unsigned MaxResults = 16;

  localparam int unsigned OpW    = 2;
  localparam int unsigned DescW  = 3;
  localparam int unsigned FileW  = 8;
  localparam int unsigned BlockW = 13;
  localparam int unsigned StatW  = 3;
  localparam int unsigned FrameW = 4;
  localparam int unsigned PinW   = 8;
  localparam int unsigned StampW = 32;

  localparam logic [OpW-1:0] OP_FETCH   = 2'd0;
  localparam logic [OpW-1:0] OP_UNPIN   = 2'd1;
  localparam logic [OpW-1:0] OP_DISPOSE = 2'd2;
  localparam logic [OpW-1:0] OP_CLOSE   = 2'd3;

  localparam logic [StatW-1:0] ST_OK         = 3'd0;
  localparam logic [StatW-1:0] ST_NO_SPACE   = 3'd1;
  localparam logic [StatW-1:0] ST_PINNED     = 3'd2;
  localparam logic [StatW-1:0] ST_NOT_BUF    = 3'd3;
  localparam logic [StatW-1:0] ST_NOT_PINNED = 3'd4;

  localparam logic [PinW-1:0] PinMax = '1;

  typedef struct packed {
    logic              used;
    logic [FileW-1:0]  file;
    logic [BlockW-1:0] block;
    logic              dirty;
    logic [PinW-1:0]   ptot;
    logic [StampW-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic match;
    logic free;
    logic victim;
    logic close_ok;
  } cmp_t;

  typedef struct packed {
    logic [StatW-1:0]  status;
    logic [FrameW-1:0] frame;
    logic              hit;
    logic              writeback;
    logic [FileW-1:0]  wb_file;
    logic [BlockW-1:0] wb_block;
    logic              last;
  } rsp_t;

endpackage

FILE: sv/lbfm_req_if.sv
// ----------------------------------------------------------------------------
// lbfm_req_if
// request channel: valid/ready handshake with one request per transaction
// ----------------------------------------------------------------------------
interface lbfm_req_if;
  import lbfm_pkg::*;

  logic              valid;
  logic              ready;
  logic [OpW-1:0]    operation;
  logic [DescW-1:0]  desc;
  logic [FileW-1:0]  file_id;
  logic [BlockW-1:0] block;
  logic              dirty;
  logic              last_open;

  modport source (output valid, operation, desc, file_id, block, dirty, last_open,
                  input ready);
  modport sink (input valid, operation, desc, file_id, block, dirty, last_open,
                output ready);
endinterface

FILE: sv/lbfm_rsp_if.sv
// ----------------------------------------------------------------------------
// lbfm_rsp_if
// response channel: valid/ready handshake with one result per transaction
// ----------------------------------------------------------------------------
interface lbfm_rsp_if;
  import lbfm_pkg::*;

  logic              valid;
  logic              ready;
  logic [StatW-1:0]  status;
  logic [FrameW-1:0] frame;
  logic              hit;
  logic              writeback;
  logic [FileW-1:0]  wb_file;
  logic [BlockW-1:0] wb_block;
  logic              last;

  modport source (output valid, status, frame, hit, writeback, wb_file, wb_block,
                  last, input ready);
  modport sink (input valid, status, frame, hit, writeback, wb_file, wb_block,
                last, output ready);
endinterface

FILE: sv/lru_buffer_frame_manager.sv
// ----------------------------------------------------------------------------
// lru_buffer_frame_manager
// buffer pool of tagged frames with pin counts and lru replacement
// ----------------------------------------------------------------------------
// usage:
//   req_i carries one request per transaction: fetch, unpin, dispose or close
//   for a descriptor, file id and block. rsp_o returns results; each request
//   gives one result, except a last close that reports one result per dirty
//   frame it writes back (at most 16, or one if none), last marking the final one.
// sequencing:
//   a request scans every frame through one shared compare unit, one frame a
//   cycle, then reads the pin count ram and executes. a last close adds a
//   second sweep over the frames, which holds while a result waits to be
//   taken. req_i.ready is high only while no request is in work.
// reset:
//   all frames come up free, pin counts read zero, the stamp clock is zero.
//   no clearing pass is needed, requests are taken right after reset.
// stall:
//   results sit in an output register; while it is full and rsp_o.ready is low the
//   block holds before writing the next result, and a new request is accepted as
//   soon as the previous one has handed its last result to the register.
// ----------------------------------------------------------------------------
module lru_buffer_frame_manager #(
  parameter int unsigned FRAMES = lbfm_pkg::FramesDef,
  parameter int unsigned DESCS  = lbfm_pkg::DescsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  lbfm_req_if.sink   req_i,
  lbfm_rsp_if.source rsp_o
);
  import lbfm_pkg::*;

  localparam int unsigned FW = $clog2(FRAMES);
  localparam int unsigned DW = (DESCS > 1) ? $clog2(DESCS) : 1;
  localparam int unsigned AW = DW + FW;
  localparam int unsigned NW = $clog2(MaxResults + 1);
  localparam logic [FW-1:0] LastFrame = FW'(FRAMES - 1);

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SCAN2 = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_CLOSE = 3'd4;
  localparam logic [2:0] S_CFIN  = 3'd5;

  // descriptor folded into range by repeated subtraction
  function automatic logic [DW-1:0] desc_fold(input logic [DescW-1:0] din);
    logic [DescW-1:0] x;
    x = din;
    for (int i = 0; i < 8; i++) begin
      if (int'(x) >= DESCS) begin
        x = x - DescW'(DESCS);
      end
    end
    return DW'(x);
  endfunction

  logic [2:0] state_q;

  // latched request
  logic [OpW-1:0]    op_q;
  logic [DW-1:0]     d_q;
  logic [FileW-1:0]  rq_file_q;
  logic [BlockW-1:0] rq_block_q;
  logic              rq_dirty_q;
  logic              rq_lopen_q;

  // scan results
  logic [FW-1:0]     k_q;
  logic              found_q;
  logic [FW-1:0]     fidx_q;
  logic              free_q;
  logic [FW-1:0]     fridx_q;
  logic              vic_q;
  logic [FW-1:0]     vidx_q;
  logic [StampW-1:0] bstamp_q;
  logic              anypin_q;
  logic              pdv_q;
  logic [FW-1:0]     sel_q;

  // close sweep
  logic [NW-1:0]     n_q;
  logic              pend_v_q;
  logic [FW-1:0]     pend_frame_q;
  logic [FileW-1:0]  pend_file_q;
  logic [BlockW-1:0] pend_block_q;

  // frame table
  logic [FRAMES-1:0] used_q;
  logic [FileW-1:0]  file_a_q  [FRAMES];
  logic [BlockW-1:0] block_a_q [FRAMES];
  logic              dirty_a_q [FRAMES];
  logic [PinW-1:0]   ptot_a_q  [FRAMES];
  logic [StampW-1:0] stamp_a_q [FRAMES];
  logic [StampW-1:0] clock_q;

  // output register
  logic out_v_q;
  rsp_t out_q;

  logic [FW-1:0]     ridx;
  entry_t            entry;
  cmp_t              cmp;
  logic [FW-1:0]     sel_c;
  logic [StampW-1:0] ns;
  logic [PinW-1:0]   pin;
  logic              slot_free;
  logic              ent_we;
  entry_t            ent_d;
  logic              clk_we;
  logic              ram_rd;
  logic [AW-1:0]     ram_raddr;
  logic              ram_we;
  logic [PinW-1:0]   ram_wdata;
  logic              ram_clr;
  logic              emit;
  rsp_t              emit_d;
  logic              take;
  logic              stall;

  // single shared read port on the frame table
  assign ridx = (state_q == S_SCAN || state_q == S_CLOSE) ? k_q : sel_q;

  assign entry.used  = used_q[ridx];
  assign entry.file  = file_a_q[ridx];
  assign entry.block = block_a_q[ridx];
  assign entry.dirty = dirty_a_q[ridx];
  assign entry.ptot  = ptot_a_q[ridx];
  assign entry.stamp = stamp_a_q[ridx];

  lbfm_frame_cmp u_cmp (
    .entry_i      (entry),
    .file_i       (rq_file_q),
    .block_i      (rq_block_q),
    .best_stamp_i (bstamp_q),
    .have_victim_i(vic_q),
    .cmp_o        (cmp)
  );

  lbfm_pin_ram #(
    .FRAMES(FRAMES),
    .DESCS (DESCS)
  ) u_pins (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (ram_rd),
    .rd_addr_i  (ram_raddr),
    .rd_data_o  (pin),
    .we_i       (ram_we),
    .wr_addr_i  ({d_q, sel_q}),
    .wr_data_i  (ram_wdata),
    .clr_en_i   (ram_clr),
    .clr_frame_i(sel_q)
  );

  // hit frame, else lowest free frame, else lru victim
  assign sel_c = (op_q != OP_FETCH || found_q) ? fidx_q :
                 free_q ? fridx_q : vidx_q;

  // saturating stamp clock
  assign ns = (clock_q == '1) ? clock_q : clock_q + StampW'(1);

  assign slot_free = !out_v_q || rsp_o.ready;

  always_comb begin
    ent_we    = 1'b0;
    ent_d     = entry;
    clk_we    = 1'b0;
    ram_rd    = 1'b0;
    ram_raddr = {d_q, k_q};
    ram_we    = 1'b0;
    ram_wdata = pin;
    ram_clr   = 1'b0;
    emit      = 1'b0;
    emit_d    = '0;
    emit_d.last = 1'b1;
    take      = 1'b0;
    stall     = 1'b0;
    unique case (state_q)
      S_SCAN: begin
        ram_rd = 1'b1;
      end
      S_SCAN2: begin
        ram_rd    = 1'b1;
        ram_raddr = {d_q, sel_c};
      end
      S_EXEC: begin
        if (slot_free) begin
          emit = 1'b1;
          unique case (op_q)
            OP_FETCH: begin
              if (found_q) begin
                emit_d.frame = FrameW'(sel_q);
                emit_d.hit   = 1'b1;
                if (pin == PinMax || entry.ptot == PinMax) begin
                  emit_d.status = ST_PINNED;
                end else begin
                  emit_d.status = ST_OK;
                  ram_we        = 1'b1;
                  ram_wdata     = pin + PinW'(1);
                  ent_we        = 1'b1;
                  ent_d.ptot    = entry.ptot + PinW'(1);
                  ent_d.stamp   = ns;
                  clk_we        = 1'b1;
                end
              end else if (!free_q && !vic_q) begin
                emit_d.status = ST_NO_SPACE;
              end else begin
                emit_d.status = ST_OK;
                emit_d.frame  = FrameW'(sel_q);
                if (!free_q && entry.dirty) begin
                  emit_d.writeback = 1'b1;
                  emit_d.wb_file   = entry.file;
                  emit_d.wb_block  = entry.block;
                end
                ram_clr     = 1'b1;
                ram_we      = 1'b1;
                ram_wdata   = PinW'(1);
                ent_we      = 1'b1;
                ent_d.used  = 1'b1;
                ent_d.file  = rq_file_q;
                ent_d.block = rq_block_q;
                ent_d.dirty = 1'b0;
                ent_d.ptot  = PinW'(1);
                ent_d.stamp = ns;
                clk_we      = 1'b1;
              end
            end
            OP_UNPIN: begin
              if (!found_q) begin
                emit_d.status = ST_NOT_BUF;
              end else if (pin == '0) begin
                emit_d.status = ST_NOT_PINNED;
                emit_d.frame  = FrameW'(sel_q);
              end else begin
                emit_d.status = ST_OK;
                emit_d.frame  = FrameW'(sel_q);
                ram_we        = 1'b1;
                ram_wdata     = pin - PinW'(1);
                ent_we        = 1'b1;
                ent_d.ptot    = (entry.ptot != '0) ? entry.ptot - PinW'(1) : entry.ptot;
                ent_d.stamp   = ns;
                ent_d.dirty   = entry.dirty | rq_dirty_q;
                clk_we        = 1'b1;
              end
            end
            OP_DISPOSE: begin
              if (!found_q) begin
                emit_d.status = ST_OK;
              end else if (entry.ptot != '0) begin
                emit_d.status = ST_PINNED;
                emit_d.frame  = FrameW'(sel_q);
              end else begin
                emit_d.status = ST_OK;
                emit_d.frame  = FrameW'(sel_q);
                ent_we        = 1'b1;
                ent_d.used    = 1'b0;
                ent_d.dirty   = 1'b0;
              end
            end
            OP_CLOSE: begin
              if (anypin_q) begin
                emit_d.status = ST_PINNED;
              end else if (!rq_lopen_q) begin
                emit_d.status = ST_OK;
              end else begin
                // results come from the sweep
                emit = 1'b0;
              end
            end
            default: emit = 1'b0;
          endcase
        end
      end
      S_CLOSE: begin
        if (cmp.close_ok) begin
          if (entry.dirty && n_q < NW'(MaxResults)) begin
            if (!pend_v_q || slot_free) begin
              // previous writeback is now known not to be the final one
              emit             = pend_v_q;
              emit_d.status    = ST_OK;
              emit_d.frame     = FrameW'(pend_frame_q);
              emit_d.writeback = 1'b1;
              emit_d.wb_file   = pend_file_q;
              emit_d.wb_block  = pend_block_q;
              emit_d.last      = 1'b0;
              take             = 1'b1;
              ent_we           = 1'b1;
              ent_d.used       = 1'b0;
              ent_d.dirty      = 1'b0;
            end else begin
              stall = 1'b1;
            end
          end else if (!entry.dirty) begin
            ent_we      = 1'b1;
            ent_d.used  = 1'b0;
            ent_d.dirty = 1'b0;
          end
        end
      end
      S_CFIN: begin
        if (slot_free) begin
          emit          = 1'b1;
          emit_d.status = ST_OK;
          if (pend_v_q) begin
            emit_d.frame     = FrameW'(pend_frame_q);
            emit_d.writeback = 1'b1;
            emit_d.wb_file   = pend_file_q;
            emit_d.wb_block  = pend_block_q;
          end
        end
      end
      default: ;
    endcase
  end

  // frame payload, no reset needed: only read for frames marked used
  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      file_a_q[ridx]  <= ent_d.file;
      block_a_q[ridx] <= ent_d.block;
      dirty_a_q[ridx] <= ent_d.dirty;
      ptot_a_q[ridx]  <= ent_d.ptot;
      stamp_a_q[ridx] <= ent_d.stamp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      op_q       <= req_i.operation;
      d_q        <= desc_fold(req_i.desc);
      rq_file_q  <= req_i.file_id;
      rq_block_q <= req_i.block;
      rq_dirty_q <= req_i.dirty;
      rq_lopen_q <= req_i.last_open;
    end
    if (emit) begin
      out_q <= emit_d;
    end
    if (state_q == S_SCAN) begin
      if (cmp.match && !found_q) begin
        fidx_q <= k_q;
      end
      if (cmp.free && !free_q) begin
        fridx_q <= k_q;
      end
      if (cmp.victim) begin
        vidx_q   <= k_q;
        bstamp_q <= entry.stamp;
      end
    end
    if (state_q == S_SCAN2) begin
      sel_q <= sel_c;
    end
    if (take) begin
      pend_frame_q <= k_q;
      pend_file_q  <= entry.file;
      pend_block_q <= entry.block;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      used_q   <= '0;
      clock_q  <= '0;
      out_v_q  <= 1'b0;
      k_q      <= '0;
      found_q  <= 1'b0;
      free_q   <= 1'b0;
      vic_q    <= 1'b0;
      anypin_q <= 1'b0;
      pdv_q    <= 1'b0;
      n_q      <= '0;
      pend_v_q <= 1'b0;
    end else begin
      if (ent_we) begin
        used_q[ridx] <= ent_d.used;
      end
      if (clk_we) begin
        clock_q <= ns;
      end
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_v_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            state_q  <= S_SCAN;
            k_q      <= '0;
            found_q  <= 1'b0;
            free_q   <= 1'b0;
            vic_q    <= 1'b0;
            anypin_q <= 1'b0;
            pdv_q    <= 1'b0;
          end
        end
        S_SCAN: begin
          if (cmp.match) begin
            found_q <= 1'b1;
          end
          if (cmp.free) begin
            free_q <= 1'b1;
          end
          if (cmp.victim) begin
            vic_q <= 1'b1;
          end
          // pin read data is registered, so it belongs to the previous scan index
          pdv_q <= 1'b1;
          if (pdv_q && pin != '0) begin
            anypin_q <= 1'b1;
          end
          k_q <= k_q + FW'(1);
          if (k_q == LastFrame) begin
            state_q <= S_SCAN2;
          end
        end
        S_SCAN2: begin
          if (pin != '0) begin
            anypin_q <= 1'b1;
          end
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (slot_free) begin
            if (op_q == OP_CLOSE && !anypin_q && rq_lopen_q) begin
              state_q  <= S_CLOSE;
              k_q      <= '0;
              n_q      <= '0;
              pend_v_q <= 1'b0;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_CLOSE: begin
          if (!stall) begin
            if (take) begin
              pend_v_q <= 1'b1;
              n_q      <= n_q + NW'(1);
            end
            k_q <= k_q + FW'(1);
            if (k_q == LastFrame) begin
              state_q <= S_CFIN;
            end
          end
        end
        S_CFIN: begin
          if (slot_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign req_i.ready = (state_q == S_IDLE);

  assign rsp_o.valid     = out_v_q;
  assign rsp_o.status    = out_q.status;
  assign rsp_o.frame     = out_q.frame;
  assign rsp_o.hit       = out_q.hit;
  assign rsp_o.writeback = out_q.writeback;
  assign rsp_o.wb_file   = out_q.wb_file;
  assign rsp_o.wb_block  = out_q.wb_block;
  assign rsp_o.last      = out_q.last;
endmodule

FILE: sv/lbfm_frame_cmp.sv
// ----------------------------------------------------------------------------
// lbfm_frame_cmp
// shared compare unit: checks one frame entry against the request per cycle
// ----------------------------------------------------------------------------
module lbfm_frame_cmp (
  input  lbfm_pkg::entry_t                 entry_i,
  input  logic [lbfm_pkg::FileW-1:0]       file_i,
  input  logic [lbfm_pkg::BlockW-1:0]      block_i,
  input  logic [lbfm_pkg::StampW-1:0]      best_stamp_i,
  input  logic                             have_victim_i,
  output lbfm_pkg::cmp_t                   cmp_o
);
  import lbfm_pkg::*;

  logic file_eq;
  logic unpinned;

  assign file_eq  = entry_i.used && (entry_i.file == file_i);
  assign unpinned = (entry_i.ptot == '0);

  assign cmp_o.match    = file_eq && (entry_i.block == block_i);
  assign cmp_o.free     = !entry_i.used;
  // ties go to the later frame
  assign cmp_o.victim   = entry_i.used && unpinned &&
                          (!have_victim_i || (entry_i.stamp <= best_stamp_i));
  assign cmp_o.close_ok = file_eq && unpinned;
endmodule

FILE: sv/lbfm_pin_ram.sv
// ----------------------------------------------------------------------------
// lbfm_pin_ram
// per descriptor and frame pin counts, with a valid bit per entry
// ----------------------------------------------------------------------------
module lbfm_pin_ram #(
  parameter  int unsigned FRAMES = lbfm_pkg::FramesDef,
  parameter  int unsigned DESCS  = lbfm_pkg::DescsDef,
  localparam int unsigned FW     = $clog2(FRAMES),
  localparam int unsigned DW     = (DESCS > 1) ? $clog2(DESCS) : 1,
  localparam int unsigned AW     = DW + FW
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [AW-1:0]             rd_addr_i,
  output logic [lbfm_pkg::PinW-1:0] rd_data_o,
  input  logic                      we_i,
  input  logic [AW-1:0]             wr_addr_i,
  input  logic [lbfm_pkg::PinW-1:0] wr_data_i,
  input  logic                      clr_en_i,
  input  logic [FW-1:0]             clr_frame_i
);
  import lbfm_pkg::*;

  localparam int unsigned Depth = 1 << AW;

  logic [PinW-1:0]  mem_q [Depth];
  logic [Depth-1:0] val_q;
  logic [PinW-1:0]  rdata_q;
  logic             rval_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  // entries never written since reset or since their frame was reloaded read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q  <= '0;
      rval_q <= 1'b0;
    end else begin
      if (rd_en_i) begin
        rval_q <= val_q[rd_addr_i];
      end
      if (clr_en_i) begin
        for (int i = 0; i < Depth; i++) begin
          if (FW'(i) == clr_frame_i) begin
            val_q[i] <= 1'b0;
          end
        end
      end
      if (we_i) begin
        val_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rval_q ? rdata_q : '0;
endmodule
